FILE: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the delimiter string splitter.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int CHAR_W            = 8;
  localparam int DELIM_BYTES_W     = 64;
  localparam int DELIM_LEN_W       = 4;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_INDEX_W       = 1;
  localparam int MAX_DELIM_LEN_DEF = 8;
  localparam int QUEUE_DEPTH       = 2;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_BYTES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_LEN   = 1'd1;

  // classified request kind: a string byte, or an end of string with no byte
  typedef enum logic {
    KIND_CHAR,
    KIND_END
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOOP,
    PH_FLUSH
  } phase_t;

endpackage

FILE: src/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Accepts input requests, drops those that carry no byte and do not end the
// string, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module dss_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [dss_pkg::CHAR_W-1:0] char_value,
  input  logic                  char_present,
  input  logic                  string_last,
  output logic                  q_valid,
  input  logic                  q_ready,
  output dss_pkg::item_t        q_item
);
  import dss_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  item_t            item_in;

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];
  assign pop      = q_valid && q_ready;
  // drop a request with no byte unless it closes the string
  assign push     = in_valid && in_ready && (char_present || string_last);

  always_comb begin
    item_in.kind = char_present ? KIND_CHAR : KIND_END;
    item_in.ch   = char_value;
    item_in.last = string_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Pending window and match engine: appends bytes, releases bytes that cannot
// start the delimiter, closes pieces on a full match, flushes at string end.
// At most one result per cycle into the output register; out_ready low stalls.
// ----------------------------------------------------------------------------
module dss_back #(
  parameter int MAX_DELIM_LEN = dss_pkg::MAX_DELIM_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  dss_pkg::item_t                  q_item,
  input  logic [dss_pkg::DELIM_BYTES_W-1:0] delim_bytes,
  input  logic [dss_pkg::DELIM_LEN_W-1:0] delim_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dss_pkg::CHAR_W-1:0]      piece_char,
  output logic                            char_valid,
  output logic                            piece_done,
  output logic                            string_done
);
  import dss_pkg::*;

  localparam int CNT_W = $clog2(MAX_DELIM_LEN + 1);

  typedef logic [MAX_DELIM_LEN-1:0][CHAR_W-1:0] win_t;

  function automatic logic prefix_ok(logic [MAX_DELIM_LEN-1:0] eq,
                                     logic [CNT_W-1:0] n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      if (CNT_W'(i) < n && !eq[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic win_t shift_win(win_t w, logic [CNT_W-1:0] amt);
    win_t r;
    r = '0;
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      for (int j = 0; j < MAX_DELIM_LEN; j++) begin
        if (j >= i && (j - i) == int'(amt)) r[i] = w[j];
      end
    end
    return r;
  endfunction

  // state
  win_t             win;
  logic [CNT_W-1:0] cnt;
  phase_t           phase;
  logic             last_flag;

  // effective state after a possible pop this cycle
  win_t             win_e;
  logic [CNT_W-1:0] cnt_e;
  phase_t           ph_e;
  logic             last_e;

  win_t                     win_next;
  logic [CNT_W-1:0]         cnt_next;
  phase_t                   phase_next;
  win_t                     dbyte;
  logic [CNT_W-1:0]         dlen;
  logic [MAX_DELIM_LEN-1:0] eq_e;
  logic [MAX_DELIM_LEN-1:0] eq_n;
  logic                     out_free;
  logic                     pop;
  logic                     full_match;
  logic                     is_close;
  logic                     is_stop;
  logic                     next_stop;
  logic                     emit;
  logic [CHAR_W-1:0]        e_char;
  logic                     e_cv;
  logic                     e_pd;
  logic                     e_sd;

  // clamp length into 1..MAX_DELIM_LEN
  always_comb begin
    if (delim_length == '0) begin
      dlen = CNT_W'(1);
    end else if (int'(delim_length) > MAX_DELIM_LEN) begin
      dlen = CNT_W'(MAX_DELIM_LEN);
    end else begin
      dlen = CNT_W'(delim_length);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      dbyte[i] = delim_bytes[CHAR_W*i +: CHAR_W];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign q_ready  = (phase == PH_IDLE) && out_free;
  assign pop      = q_valid && q_ready;

  always_comb begin
    win_e  = win;
    cnt_e  = cnt;
    ph_e   = phase;
    last_e = last_flag;
    if (pop) begin
      if (q_item.kind == KIND_CHAR) begin
        // a full window drops the new byte
        if (cnt < CNT_W'(MAX_DELIM_LEN)) begin
          for (int i = 0; i < MAX_DELIM_LEN; i++) begin
            if (CNT_W'(i) == cnt) win_e[i] = q_item.ch;
          end
          cnt_e = cnt + CNT_W'(1);
        end
        ph_e   = PH_LOOP;
        last_e = q_item.last;
      end else begin
        ph_e   = PH_FLUSH;
        last_e = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      eq_e[i] = (win_e[i] == dbyte[i]);
    end
  end

  assign full_match = (cnt_e >= dlen) && prefix_ok(eq_e, dlen);
  assign is_close   = (ph_e == PH_LOOP) && full_match;
  assign is_stop    = (ph_e == PH_LOOP) && (cnt_e < dlen) && prefix_ok(eq_e, cnt_e);

  // result and window update
  always_comb begin
    emit     = 1'b0;
    e_char   = '0;
    e_cv     = 1'b0;
    e_pd     = 1'b0;
    e_sd     = 1'b0;
    win_next = win_e;
    cnt_next = cnt_e;
    case (ph_e)
      PH_LOOP: begin
        if (is_close) begin
          emit     = 1'b1;
          e_pd     = 1'b1;
          win_next = shift_win(win_e, dlen);
          cnt_next = cnt_e - dlen;
        end else if (!is_stop) begin
          emit     = 1'b1;
          e_char   = win_e[0];
          e_cv     = 1'b1;
          win_next = shift_win(win_e, CNT_W'(1));
          cnt_next = cnt_e - CNT_W'(1);
        end
      end
      PH_FLUSH: begin
        emit = 1'b1;
        if (cnt_e != '0) begin
          e_char   = win_e[0];
          e_cv     = 1'b1;
          win_next = shift_win(win_e, CNT_W'(1));
          cnt_next = cnt_e - CNT_W'(1);
        end else begin
          e_pd = 1'b1;
          e_sd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // look ahead: does the updated window end the scan for this byte
  always_comb begin
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      eq_n[i] = (win_next[i] == dbyte[i]);
    end
  end

  assign next_stop = (cnt_next < dlen) && prefix_ok(eq_n, cnt_next);

  always_comb begin
    case (ph_e)
      PH_LOOP: begin
        if (is_stop || next_stop) begin
          phase_next = last_e ? PH_FLUSH : PH_IDLE;
        end else begin
          phase_next = PH_LOOP;
        end
      end
      PH_FLUSH: begin
        phase_next = (cnt_e == '0) ? PH_IDLE : PH_FLUSH;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (out_free) begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      win         <= win_next;
      last_flag   <= last_e;
      piece_char  <= e_char;
      char_valid  <= e_cv;
      piece_done  <= e_pd;
      string_done <= e_sd;
    end
  end

endmodule

FILE: src/delimiter_string_splitter.sv
// ----------------------------------------------------------------------------
// delimiter_string_splitter
// Splits a byte string on a configurable delimiter of 1 to MAX_DELIM_LEN bytes (8 by default).
// ----------------------------------------------------------------------------
// Path: an accepted byte passes through a queue entry, then the output register.
// Order: the match engine takes a new byte only while idle, once it is done
//   with the last byte; the end of a string flushes each pending byte, then
//   the close.
// Reset: window empty, delimiter cleared, length 1; no result pending.
module delimiter_string_splitter #(
  parameter int MAX_DELIM_LEN = dss_pkg::MAX_DELIM_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dss_pkg::CHAR_W-1:0]        char_value,
  input  logic                              char_present,
  input  logic                              string_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dss_pkg::CHAR_W-1:0]        piece_char,
  output logic                              char_valid,
  output logic                              piece_done,
  output logic                              string_done
);
  import dss_pkg::*;

  logic [DELIM_BYTES_W-1:0] delim_bytes;
  logic [DELIM_LEN_W-1:0]   delim_length;
  logic                     q_valid;
  logic                     q_ready;
  item_t                    q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes  <= '0;
      delim_length <= DELIM_LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DELIM_BYTES: delim_bytes  <= cfg_data[DELIM_BYTES_W-1:0];
        CFG_DELIM_LEN:   delim_length <= cfg_data[DELIM_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dss_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_value   (char_value),
    .char_present (char_present),
    .string_last  (string_last),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  dss_back #(
    .MAX_DELIM_LEN (MAX_DELIM_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .delim_bytes  (delim_bytes),
    .delim_length (delim_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .piece_char   (piece_char),
    .char_valid   (char_valid),
    .piece_done   (piece_done),
    .string_done  (string_done)
  );

`ifndef SYNTHESIS
  a_byte_or_close: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid != piece_done))
    else $error("result must carry exactly one of byte or close");

  a_done_is_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> piece_done && !char_valid)
    else $error("string end must be a piece close");

  a_empty_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> piece_char == '0)
    else $error("close result carries a nonzero byte");
`endif

endmodule
